FILE: design/erv_pkg.sv
package erv_pkg;

    // default field widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 30;
    localparam int XY_WIDTH     = 34;   // cordic x/y lanes, signed
    localparam int Z_WIDTH      = 33;   // residual angle, signed, 2^32 per turn
    localparam int TRIG_WIDTH   = 32;   // Q1.30 sine/cosine, signed
    localparam int MAT_WIDTH    = 34;   // matrix entry, signed Q1.30 with headroom

    localparam logic signed [XY_WIDTH-1:0] CORDIC_GAIN = XY_WIDTH'(652032874);
    localparam logic signed [XY_WIDTH-1:0] TRIG_ONE    = XY_WIDTH'(64'sd1073741824);

    // arctangent per step, 2^32 per turn
    function automatic logic [31:0] atan_of(input int step);
        logic [31:0] r;
        case (step)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Q1.30 product, round half up
    function automatic logic signed [TRIG_WIDTH-1:0] mul30(
        input logic signed [TRIG_WIDTH-1:0] a,
        input logic signed [TRIG_WIDTH-1:0] b
    );
        logic signed [2*TRIG_WIDTH-1:0] p;
        p = a * b;
        p = p + (2*TRIG_WIDTH)'(64'sd536870912);
        p = p >>> 30;
        return p[TRIG_WIDTH-1:0];
    endfunction

endpackage

FILE: design/erv_cordic_cell.sv
// one CORDIC micro-rotation for all three axes, vector carried alongside
module erv_cordic_cell #(
    parameter int STEP        = 0,
    parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  logic signed [erv_pkg::XY_WIDTH-1:0]  x_in [3],
    input  logic signed [erv_pkg::XY_WIDTH-1:0]  y_in [3],
    input  logic signed [erv_pkg::Z_WIDTH-1:0]   z_in [3],
    input  logic        [2:0]                    flip_in,
    input  logic        [3*COORD_WIDTH-1:0]      vec_in,
    output logic                                 valid_out,
    output logic signed [erv_pkg::XY_WIDTH-1:0]  x_out [3],
    output logic signed [erv_pkg::XY_WIDTH-1:0]  y_out [3],
    output logic signed [erv_pkg::Z_WIDTH-1:0]   z_out [3],
    output logic        [2:0]                    flip_out,
    output logic        [3*COORD_WIDTH-1:0]      vec_out
);

    localparam logic signed [erv_pkg::Z_WIDTH-1:0] ATAN =
        erv_pkg::Z_WIDTH'(erv_pkg::atan_of(STEP));

    logic                                valid_reg;
    logic signed [erv_pkg::XY_WIDTH-1:0] x_reg [3];
    logic signed [erv_pkg::XY_WIDTH-1:0] y_reg [3];
    logic signed [erv_pkg::Z_WIDTH-1:0]  z_reg [3];
    logic signed [erv_pkg::XY_WIDTH-1:0] x_next [3];
    logic signed [erv_pkg::XY_WIDTH-1:0] y_next [3];
    logic signed [erv_pkg::Z_WIDTH-1:0]  z_next [3];
    logic        [2:0]                   flip_reg;
    logic        [3*COORD_WIDTH-1:0]     vec_reg;

    // rotate towards zero residual angle
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!z_in[k][erv_pkg::Z_WIDTH-1]) begin
                x_next[k] = x_in[k] - (y_in[k] >>> STEP);
                y_next[k] = y_in[k] + (x_in[k] >>> STEP);
                z_next[k] = z_in[k] - ATAN;
            end else begin
                x_next[k] = x_in[k] + (y_in[k] >>> STEP);
                y_next[k] = y_in[k] - (x_in[k] >>> STEP);
                z_next[k] = z_in[k] + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            flip_reg <= flip_in;
            vec_reg  <= vec_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign flip_out  = flip_reg;
    assign vec_out   = vec_reg;

endmodule

FILE: design/erv_matrix.sv
// sine/cosine clean-up and the nine entries of Rx*Ry*Rz, three stages
module erv_matrix #(
    parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  logic signed [erv_pkg::XY_WIDTH-1:0]   cos_in [3],
    input  logic signed [erv_pkg::XY_WIDTH-1:0]   sin_in [3],
    input  logic        [2:0]                     flip_in,
    input  logic        [3*COORD_WIDTH-1:0]       vec_in,
    output logic                                  valid_out,
    output logic signed [erv_pkg::MAT_WIDTH-1:0]  mat_out [9],
    output logic        [3*COORD_WIDTH-1:0]       vec_out
);

    localparam int TW = erv_pkg::TRIG_WIDTH;
    localparam int MW = erv_pkg::MAT_WIDTH;

    logic signed [TW-1:0] cs [3];
    logic signed [TW-1:0] sn [3];

    logic [2:0] valid_reg;
    logic [3*COORD_WIDTH-1:0] vec1_reg, vec2_reg, vec3_reg;

    // first products
    logic signed [TW-1:0] bd_reg, ad_reg, ce1_reg, cf1_reg, af1_reg, ae1_reg;
    logic signed [TW-1:0] bc1_reg, bf1_reg, be1_reg, ac1_reg, d1_reg, e1_reg, f1_reg;
    // second products
    logic signed [TW-1:0] bde_reg, bdf_reg, ade_reg, adf_reg;
    logic signed [TW-1:0] ce2_reg, cf2_reg, af2_reg, ae2_reg;
    logic signed [TW-1:0] bc2_reg, bf2_reg, be2_reg, ac2_reg, d2_reg;
    logic signed [MW-1:0] mat_reg [9];

    // clamp to unity and undo the half-turn fold
    always_comb begin
        logic signed [erv_pkg::XY_WIDTH-1:0] c, s;
        for (int k = 0; k < 3; k++) begin
            c = cos_in[k];
            s = sin_in[k];
            if (c > erv_pkg::TRIG_ONE) c = erv_pkg::TRIG_ONE;
            if (c < -erv_pkg::TRIG_ONE) c = -erv_pkg::TRIG_ONE;
            if (s > erv_pkg::TRIG_ONE) s = erv_pkg::TRIG_ONE;
            if (s < -erv_pkg::TRIG_ONE) s = -erv_pkg::TRIG_ONE;
            if (flip_in[k]) begin
                c = -c;
                s = -s;
            end
            cs[k] = c[TW-1:0];
            sn[k] = s[TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    // A=cs0 B=sn0 C=cs1 D=sn1 E=cs2 F=sn2
    always_ff @(posedge aclk) begin
        if (en) begin
            bd_reg   <= erv_pkg::mul30(sn[0], sn[1]);
            ad_reg   <= erv_pkg::mul30(cs[0], sn[1]);
            ce1_reg  <= erv_pkg::mul30(cs[1], cs[2]);
            cf1_reg  <= erv_pkg::mul30(cs[1], sn[2]);
            af1_reg  <= erv_pkg::mul30(cs[0], sn[2]);
            ae1_reg  <= erv_pkg::mul30(cs[0], cs[2]);
            bc1_reg  <= erv_pkg::mul30(sn[0], cs[1]);
            bf1_reg  <= erv_pkg::mul30(sn[0], sn[2]);
            be1_reg  <= erv_pkg::mul30(sn[0], cs[2]);
            ac1_reg  <= erv_pkg::mul30(cs[0], cs[1]);
            d1_reg   <= sn[1];
            e1_reg   <= cs[2];
            f1_reg   <= sn[2];
            vec1_reg <= vec_in;

            bde_reg  <= erv_pkg::mul30(bd_reg, e1_reg);
            bdf_reg  <= erv_pkg::mul30(bd_reg, f1_reg);
            ade_reg  <= erv_pkg::mul30(ad_reg, e1_reg);
            adf_reg  <= erv_pkg::mul30(ad_reg, f1_reg);
            ce2_reg  <= ce1_reg;
            cf2_reg  <= cf1_reg;
            af2_reg  <= af1_reg;
            ae2_reg  <= ae1_reg;
            bc2_reg  <= bc1_reg;
            bf2_reg  <= bf1_reg;
            be2_reg  <= be1_reg;
            ac2_reg  <= ac1_reg;
            d2_reg   <= d1_reg;
            vec2_reg <= vec1_reg;

            mat_reg[0] <= MW'(ce2_reg);
            mat_reg[1] <= -MW'(cf2_reg);
            mat_reg[2] <= MW'(d2_reg);
            mat_reg[3] <= MW'(bde_reg) + MW'(af2_reg);
            mat_reg[4] <= MW'(ae2_reg) - MW'(bdf_reg);
            mat_reg[5] <= -MW'(bc2_reg);
            mat_reg[6] <= MW'(bf2_reg) - MW'(ade_reg);
            mat_reg[7] <= MW'(adf_reg) + MW'(be2_reg);
            mat_reg[8] <= MW'(ac2_reg);
            vec3_reg   <= vec2_reg;
        end
    end

    assign valid_out = valid_reg[2];
    assign mat_out   = mat_reg;
    assign vec_out   = vec3_reg;

endmodule

FILE: design/erv_dot.sv
// matrix times vector, one rounding, saturation; two stages
module erv_dot #(
    parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  logic signed [erv_pkg::MAT_WIDTH-1:0]  mat_in [9],
    input  logic        [3*COORD_WIDTH-1:0]       vec_in,
    output logic                                  valid_out,
    output logic        [3*COORD_WIDTH-1:0]       res_out
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + erv_pkg::MAT_WIDTH;
    localparam int SW = PW + 2;
    localparam int RW = SW - 30;
    // coordinate range limits, signed at the rounded width
    localparam logic signed [RW-1:0] RES_MAX = RW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [RW-1:0] RES_MIN = ~RES_MAX;

    logic [1:0]           valid_reg;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [CW-1:0] res_reg  [3];
    logic signed [CW-1:0] res_next [3];
    logic signed [CW-1:0] v        [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            v[j] = vec_in[j*CW +: CW];
        end
    end

    // round half up, clamp to the coordinate range
    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [RW-1:0] r;
        for (int i = 0; i < 3; i++) begin
            acc = SW'(prod_reg[3*i]) + SW'(prod_reg[3*i+1]) + SW'(prod_reg[3*i+2])
                + SW'(64'sd536870912);
            r = RW'(acc >>> 30);
            if (r > RES_MAX)
                res_next[i] = RES_MAX[CW-1:0];
            else if (r < RES_MIN)
                res_next[i] = RES_MIN[CW-1:0];
            else
                res_next[i] = r[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], valid_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[3*i+j] <= PW'(v[j]) * PW'(mat_in[3*i+j]);
                end
            end
            res_reg <= res_next;
        end
    end

    assign valid_out = valid_reg[1];
    assign res_out   = {res_reg[2], res_reg[1], res_reg[0]};

endmodule

FILE: design/euler_rotation_vec3_top.sv
// Rotates a Q16.16 vector by M = Rx*Ry*Rz (z applied first). One vector is taken
// per clock while the output is not stalled; each result passes through the
// CORDIC cells that form all six sines and cosines in parallel, then the stages for the
// matrix entries and those for the multiply, round and saturate. The whole pipeline
// halts together while a finished result waits on m_axis_tready.
module euler_rotation_vec3_top #(
    parameter int COORD_WIDTH = erv_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = erv_pkg::ANGLE_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x_in, y_in, z_in, angle_x, angle_y, angle_z (lowest bits first), zero pad
    input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // x_out, y_out, z_out (lowest bits first), zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int N   = erv_pkg::CORDIC_STEPS;
    localparam int XW  = erv_pkg::XY_WIDTH;
    localparam int ZW  = erv_pkg::Z_WIDTH;
    localparam int ODW = ((3*CW+7)/8)*8;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

    logic en;

    logic                 cv   [N+1];
    logic signed [XW-1:0] cx   [N+1][3];
    logic signed [XW-1:0] cy   [N+1][3];
    logic signed [ZW-1:0] cz   [N+1][3];
    logic        [2:0]    cf   [N+1];
    logic [3*CW-1:0]      cvec [N+1];

    logic                                 mat_valid;
    logic signed [erv_pkg::MAT_WIDTH-1:0] mat [9];
    logic [3*CW-1:0]                      mat_vec;
    logic [3*CW-1:0]                      res;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // fold each angle into a quarter turn either side of zero
    always_comb begin
        logic signed [ZW-1:0] z;
        cv[0]   = s_axis_tvalid;
        cvec[0] = s_axis_tdata[3*CW-1:0];
        for (int k = 0; k < 3; k++) begin
            z = ZW'(signed'({s_axis_tdata[3*CW+k*AW +: AW], {(32-AW){1'b0}}}));
            cf[0][k] = 1'b0;
            if (z > QUARTER) begin
                z = z - HALF;
                cf[0][k] = 1'b1;
            end else if (z < -QUARTER) begin
                z = z + HALF;
                cf[0][k] = 1'b1;
            end
            cz[0][k] = z;
            cx[0][k] = erv_pkg::CORDIC_GAIN;
            cy[0][k] = '0;
        end
    end

    // CORDIC cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        erv_cordic_cell #(
            .STEP        (g),
            .COORD_WIDTH (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (cv[g]),
            .x_in      (cx[g]),
            .y_in      (cy[g]),
            .z_in      (cz[g]),
            .flip_in   (cf[g]),
            .vec_in    (cvec[g]),
            .valid_out (cv[g+1]),
            .x_out     (cx[g+1]),
            .y_out     (cy[g+1]),
            .z_out     (cz[g+1]),
            .flip_out  (cf[g+1]),
            .vec_out   (cvec[g+1])
        );
    end

    erv_matrix #(
        .COORD_WIDTH (CW)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (cv[N]),
        .cos_in    (cx[N]),
        .sin_in    (cy[N]),
        .flip_in   (cf[N]),
        .vec_in    (cvec[N]),
        .valid_out (mat_valid),
        .mat_out   (mat),
        .vec_out   (mat_vec)
    );

    erv_dot #(
        .COORD_WIDTH (CW)
    ) u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (mat_valid),
        .mat_in    (mat),
        .vec_in    (mat_vec),
        .valid_out (m_axis_tvalid),
        .res_out   (res)
    );

    assign m_axis_tdata = ODW'(res);

`ifndef NO_ASSERTIONS
    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // folded angle stays within a quarter turn
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cz[0][0] <= QUARTER) && (cz[0][0] >= -QUARTER)
        && (cz[0][1] <= QUARTER) && (cz[0][1] >= -QUARTER)
        && (cz[0][2] <= QUARTER) && (cz[0][2] >= -QUARTER))
        else $error("angle fold out of range");

    // an item entering the last stage surfaces while the pipe moves
    a_tail_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && u_dot.valid_reg[0]) |=> m_axis_tvalid)
        else $error("item lost in final stage");
`endif

endmodule

FILE: dv/euler_rotation_vec3_top_test.sv
module euler_rotation_vec3_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = erv_pkg::COORD_WIDTH_DEF;
    localparam int AW = erv_pkg::ANGLE_WIDTH_DEF;
    localparam int SW = ((3*CW+3*AW+7)/8)*8;
    localparam int MW = ((3*CW+7)/8)*8;
    localparam int LATENCY = 35;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } vec_t;

    logic          aclk;
    logic          aresetn;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [SW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [MW-1:0] m_axis_tdata;

    euler_rotation_vec3_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    vec_t   rotated_q[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;
    int     mismatches;
    int     unexpected;
    int     vectors_sent;
    int     vectors_checked;
    int     quiet_cycles;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor shift right of a signed 64-bit value
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    // CORDIC sine/cosine of a binary angle, Q1.30
    function automatic void angle_trig(input logic [AW-1:0] ang, output longint c,
                                       output longint s);
        logic [31:0] t;
        longint z, x, y, nx, a;
        bit flip;
        t = {ang, {(32-AW){1'b0}}};
        z = longint'(signed'(t));
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31; flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31; flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            a = longint'(erv_pkg::atan_of(i));
            if (z >= 0) begin
                nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= a;
            end else begin
                nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += a;
            end
            x = nx;
        end
        if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
        if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
        if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
        if (y < -(64'sd1 <<< 30)) y = -(64'sd1 <<< 30);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // expected rotated vector: exact sums, one rounding, saturation
    function automatic vec_t rotate_vec(vec_t v, logic [AW-1:0] ax, logic [AW-1:0] ay,
                                        logic [AW-1:0] az);
        longint ca, sa, cb, sb, ce, se, bd, ad;
        longint m[3][3];
        logic signed [127:0] acc;
        logic signed [127:0] vj[3];
        logic signed [CW-1:0] res[3];
        vec_t r;
        angle_trig(ax, ca, sa);
        angle_trig(ay, cb, sb);
        angle_trig(az, ce, se);
        bd = q30_mul(sa, sb);
        ad = q30_mul(ca, sb);
        m[0][0] = q30_mul(cb, ce);
        m[0][1] = -q30_mul(cb, se);
        m[0][2] = sb;
        m[1][0] = q30_mul(bd, ce) + q30_mul(ca, se);
        m[1][1] = q30_mul(ca, ce) - q30_mul(bd, se);
        m[1][2] = -q30_mul(sa, cb);
        m[2][0] = q30_mul(sa, se) - q30_mul(ad, ce);
        m[2][1] = q30_mul(ad, se) + q30_mul(sa, ce);
        m[2][2] = q30_mul(ca, cb);
        vj[0] = 128'(v.x);
        vj[1] = 128'(v.y);
        vj[2] = 128'(v.z);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += vj[j] * 128'(m[i][j]);
            acc = (acc + (128'sd1 <<< 29)) >>> 30;
            if (acc > 128'((64'sd1 <<< (CW-1)) - 1))
                res[i] = {1'b0, {(CW-1){1'b1}}};
            else if (acc < -128'(64'sd1 <<< (CW-1)))
                res[i] = {1'b1, {(CW-1){1'b0}}};
            else
                res[i] = acc[CW-1:0];
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        return r;
    endfunction

    // offer one vector, with random idle before it, and wait for the transfer
    task automatic send_vector(vec_t v, logic [AW-1:0] ax, logic [AW-1:0] ay,
                               logic [AW-1:0] az);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= SW'({az, ay, ax, v.z, v.y, v.x});
        rotated_q.push_back(rotate_vec(v, ax, ay, az));
        vectors_sent++;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return CW'($urandom_range(65536 * 4)) - CW'(65536 * 2);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(7))
            0: return AW'(16'h4000 * $urandom_range(3));
            1: return AW'(16'h4000 * $urandom_range(3) + $urandom_range(2)) - AW'(1);
            default: return AW'($urandom);
        endcase
    endfunction

    task automatic send_random(int n);
        vec_t v;
        for (int i = 0; i < n; i++) begin
            v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
            send_vector(v, rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // receiver ready: random idling, or a long hold-off
    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        vec_t got, want;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d vectors still expected", rotated_q.size());
                $display("[euler_rotation_vec3_top] ERROR");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[3*CW-1:0];
                if (rotated_q.size() == 0) begin
                    unexpected++;
                    $display("result with nothing expected: %h", got);
                end else begin
                    want = rotated_q.pop_front();
                    vectors_checked++;
                    // pad bits above the three fields must read as zero
                    if (m_axis_tdata !== MW'(want)) begin
                        if (mismatches < 10)
                            $display("mismatch #%0d: want x=%h y=%h z=%h got x=%h y=%h z=%h",
                                     vectors_checked, want.x, want.y, want.z,
                                     got.x, got.y, got.z);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge aclk);
    endtask

    // corners: zero angles, quarter turns, coordinate extremes, saturation
    task automatic test_directed();
        vec_t v;
        logic [AW-1:0] quarter [5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
        v.x = 32'sh0001_0000; v.y = 32'sh0002_0000; v.z = 32'sh0003_0000;
        send_vector(v, 0, 0, 0);
        for (int i = 1; i < 5; i++) begin
            send_vector(v, quarter[i], 0, 0);
            send_vector(v, 0, quarter[i], 0);
            send_vector(v, 0, 0, quarter[i]);
        end
        v.x = {1'b0, {(CW-1){1'b1}}}; v.y = v.x; v.z = v.x;
        send_vector(v, 16'h2000, 16'h2000, 16'h2000);
        v.x = {1'b1, {(CW-1){1'b0}}}; v.y = v.x; v.z = v.x;
        send_vector(v, 16'hE000, 16'h2000, 16'h6000);
        send_vector(v, 0, 0, 0);
        v.x = '1; v.y = 0; v.z = '1;
        send_vector(v, 16'h5555, 16'hAAAA, 16'h1234);
        send_vector(v, 16'h4001, 16'h3FFF, 16'hBFFF);
    endtask

    // receiver held off long enough to back the pipeline up
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1;
                repeat (150) @(posedge aclk);
                recv_hold = 0;
            end
            send_random(80);
        join
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        recv_hold = 0;
        send_idle_pct = 24;
        recv_idle_pct = 55;
        mismatches = 0; unexpected = 0; vectors_sent = 0; vectors_checked = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        send_random(440);
        send_idle_pct = 55; recv_idle_pct = 24;
        send_random(440);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(440);
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("covered %0d vectors (%0d checked): axis quarter turns, coordinate",
                 vectors_sent, vectors_checked);
        $display("extremes with saturation, random angles, idling and a long stall");
        if (mismatches == 0 && unexpected == 0 && rotated_q.size() == 0)
            $display("[euler_rotation_vec3_top] OK");
        else
            $display("[euler_rotation_vec3_top] ERROR");
        $finish;
    end
endmodule

FILE: euler_rotation_vec3_top.f
design/erv_pkg.sv
design/erv_cordic_cell.sv
design/erv_matrix.sv
design/erv_dot.sv
design/euler_rotation_vec3_top.sv
dv/euler_rotation_vec3_top_test.sv
